// ===== design/glws_pkg.sv =====
// Shared constants, types and arithmetic helpers of the gradient-weighted sharpener.
package glws_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int RING_LINES = 8;
	localparam int LINE_W = $clog2(RING_LINES);
	localparam int ADDR_W = LINE_W + COL_W;
	localparam int DEPTH = RING_LINES * MAX_WIDTH;
	localparam int PIX_W = 24;
	localparam int NUM_CH = 3;
	localparam int WIN_N = 25;
	localparam int SQ_W = 22;
	localparam int ROOT_W = SQ_W / 2;
	localparam int SUM_W = 12;

	localparam logic [11:0] WIDTH_RESET = 12'd640;
	localparam logic [15:0] HEIGHT_RESET = 16'd480;

	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef logic [7:0] chan_t;
	typedef logic [PIX_W-1:0] pix_t;

	function automatic chan_t div9(input logic [SUM_W-1:0] s);
		logic [25:0] p;
		p = {14'b0, s} * 26'd7282;
		return p[23:16];
	endfunction

	function automatic chan_t div255(input logic [15:0] x);
		logic [31:0] p;
		p = {16'b0, x} * 32'd32897;
		return p[30:23];
	endfunction

endpackage

// ===== design/glws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module glws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/glws_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module glws_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [glws_pkg::SQ_W-1:0]    value,
	output logic                         done,
	output logic [glws_pkg::ROOT_W-1:0]  root
);

	logic [glws_pkg::SQ_W-1:0] rem_q, res_q, bit_q, trial;

	assign trial = res_q + bit_q;
	assign done = (bit_q == '0);
	assign root = res_q[glws_pkg::ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (start) begin
			bit_q <= glws_pkg::SQ_W'(1) << (glws_pkg::SQ_W - 2);
		end else if (!done) begin
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
		end else if (!done) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

endmodule

// ===== design/gradient_weighted_laplacian_sharpen_top.sv =====
// Top level: line ring memory, 5x5 window loader and sharpening sequencer.
// A pixel that emits nothing is taken without leaving IDLE; an emitting item holds
// off new input until its result is loaded, set by 25 serial window reads from the
// line memory, nine serial Sobel square roots for an interior pixel only (three
// lanes in parallel) and any output stall. Output lags input by 2*W+2 pixels.
// Reset (arst_n low) clears counters and handshake, resets sizes; line memory is not cleared.
module gradient_weighted_laplacian_sharpen_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // in_blue, in_green, in_red
	input  logic [0:0]  s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_blue, out_green, out_red
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [3:0] {
		IDLE, RD, RDW, LAP, SQ, ST, WT, MEAN, PROD, SCALE, OUT
	} state_t;

	localparam int NC = glws_pkg::NUM_CH;

	state_t state_q;
	logic [11:0] width_q, eff_w, col_cnt_q, out_col_q, col_inc, ocol_inc;
	logic [15:0] height_q, eff_h, row_cnt_q, out_row_q, row_inc, orow_inc;
	logic [2:0] in_line_q, out_line_q, ir_q, ik_q, rd_line;
	logic [1:0] pr_q, pk_q;
	logic [12:0] pend_q, pend_inc, thr, rd_col, sob_t;
	logic [16:0] sob_s;
	logic acc, interior, sob_zero, zf_q, done_all, cap_v_s1, cap_ok_s1, rotate;
	logic [glws_pkg::ADDR_W-1:0] raddr, waddr;
	glws_pkg::pix_t rdata, win_q [glws_pkg::WIN_N];
	logic m_tvalid_q, m_tlast_q;
	logic [23:0] m_tdata_q;

	glws_pkg::chan_t orig_q [NC], lap_q [NC], mean_q [NC], res_q [NC];
	glws_pkg::chan_t lap_c [NC];
	logic [15:0] prod_q [NC];
	logic [glws_pkg::SUM_W-1:0] sum_q [NC];
	logic [glws_pkg::SQ_W-2:0] sqx_q [NC], sqy_q [NC], sqx_c [NC], sqy_c [NC];
	logic [glws_pkg::ROOT_W-1:0] root [NC];
	logic done [NC];

	assign s_tready = (state_q == IDLE);
	assign acc = s_tvalid & s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;

	always_comb begin
		eff_w = width_q;
		if (width_q < 12'd3) begin
			eff_w = 12'd3;
		end else if (width_q > 12'(glws_pkg::MAX_WIDTH)) begin
			eff_w = 12'(glws_pkg::MAX_WIDTH);
		end
		eff_h = (height_q < 16'd3) ? 16'd3 : height_q;
	end

	assign thr = {eff_w, 1'b0} + 13'd2;
	assign pend_inc = pend_q + 13'd1;
	assign col_inc = col_cnt_q + 12'd1;
	assign row_inc = row_cnt_q + 16'd1;
	assign ocol_inc = out_col_q + 12'd1;
	assign orow_inc = out_row_q + 16'd1;
	assign interior = (out_row_q >= 16'd1) && (out_row_q <= eff_h - 16'd2)
		&& (out_col_q >= 12'd1) && (out_col_q <= eff_w - 12'd2);

	assign waddr = {in_line_q, col_cnt_q[glws_pkg::COL_W-1:0]};
	assign rd_line = out_line_q + ir_q + 3'd6;
	assign rd_col = {1'b0, out_col_q} + {10'b0, ik_q} - 13'd2;
	assign raddr = {rd_line, rd_col[glws_pkg::COL_W-1:0]};

	glws_ram #(.WIDTH(glws_pkg::PIX_W), .DEPTH(glws_pkg::DEPTH)) u_lines (
		.clk(clk), .we(acc & ~s_tuser[0]), .waddr(waddr), .wdata(s_tdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign sob_s = {1'b0, out_row_q} + {15'b0, pr_q} - 17'd1;
	assign sob_t = {1'b0, out_col_q} + {11'b0, pk_q} - 13'd1;
	assign sob_zero = (sob_s == '0) || (sob_s >= {1'b0, eff_h - 16'd1})
		|| (sob_t == '0) || (sob_t >= {1'b0, eff_w - 12'd1});
	assign rotate = (state_q == WT) && done_all && !(pr_q == 2'd2 && pk_q == 2'd2);

	always_comb begin
		logic signed [12:0] lw;
		logic signed [11:0] gx, gy;
		logic signed [23:0] px2, py2;
		for (int c = 0; c < NC; c++) begin
			lw = $signed({3'b0, win_q[12][8*c +: 8], 2'b0})
				- $signed({5'b0, win_q[7][8*c +: 8]}) - $signed({5'b0, win_q[17][8*c +: 8]})
				- $signed({5'b0, win_q[11][8*c +: 8]}) - $signed({5'b0, win_q[13][8*c +: 8]});
			if (lw < 0) begin
				lap_c[c] = 8'd0;
			end else if (lw > 13'sd255) begin
				lap_c[c] = 8'd255;
			end else begin
				lap_c[c] = lw[7:0];
			end
			gx = $signed({4'b0, win_q[2][8*c +: 8]}) + $signed({3'b0, win_q[7][8*c +: 8], 1'b0})
				+ $signed({4'b0, win_q[12][8*c +: 8]}) - $signed({4'b0, win_q[0][8*c +: 8]})
				- $signed({3'b0, win_q[5][8*c +: 8], 1'b0}) - $signed({4'b0, win_q[10][8*c +: 8]});
			gy = $signed({4'b0, win_q[10][8*c +: 8]}) + $signed({3'b0, win_q[11][8*c +: 8], 1'b0})
				+ $signed({4'b0, win_q[12][8*c +: 8]}) - $signed({4'b0, win_q[0][8*c +: 8]})
				- $signed({3'b0, win_q[1][8*c +: 8], 1'b0}) - $signed({4'b0, win_q[2][8*c +: 8]});
			px2 = {{12{gx[11]}}, gx} * {{12{gx[11]}}, gx};
			py2 = {{12{gy[11]}}, gy} * {{12{gy[11]}}, gy};
			sqx_c[c] = px2[glws_pkg::SQ_W-2:0];
			sqy_c[c] = py2[glws_pkg::SQ_W-2:0];
		end
	end

	for (genvar c = 0; c < NC; c++) begin : g_lane
		glws_isqrt u_isqrt (
			.clk(clk), .arst_n(arst_n), .start(state_q == ST),
			.value({1'b0, sqx_q[c]} + {1'b0, sqy_q[c]}),
			.done(done[c]), .root(root[c])
		);
	end

	assign done_all = done[0] & done[1] & done[2];

	always_ff @(posedge clk) begin
		if (cap_v_s1) begin
			for (int i = 0; i < glws_pkg::WIN_N - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[glws_pkg::WIN_N-1] <= cap_ok_s1 ? rdata : '0;
		end else if (rotate) begin
			if (pk_q == 2'd2) begin
				for (int i = 0; i < glws_pkg::WIN_N; i++) begin
					win_q[i] <= win_q[(i + 3) % glws_pkg::WIN_N];
				end
			end else begin
				for (int i = 0; i < glws_pkg::WIN_N; i++) begin
					win_q[i] <= win_q[(i + 1) % glws_pkg::WIN_N];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cap_ok_s1 <= (rd_col[12:glws_pkg::COL_W] == '0);
		unique case (state_q)
			LAP: begin
				for (int c = 0; c < NC; c++) begin
					lap_q[c] <= lap_c[c];
					orig_q[c] <= win_q[12][8*c +: 8];
					res_q[c] <= win_q[12][8*c +: 8];
					sum_q[c] <= '0;
				end
			end
			SQ: begin
				zf_q <= sob_zero;
				for (int c = 0; c < NC; c++) begin
					sqx_q[c] <= sqx_c[c];
					sqy_q[c] <= sqy_c[c];
				end
			end
			WT: begin
				if (done_all && !zf_q) begin
					for (int c = 0; c < NC; c++) begin
						sum_q[c] <= sum_q[c] + ((root[c] > 11'd255) ? 12'd255
							: {1'b0, root[c]});
					end
				end
			end
			MEAN: begin
				for (int c = 0; c < NC; c++) begin
					mean_q[c] <= glws_pkg::div9(sum_q[c]);
				end
			end
			PROD: begin
				for (int c = 0; c < NC; c++) begin
					prod_q[c] <= {8'b0, lap_q[c]} * {8'b0, mean_q[c]};
				end
			end
			SCALE: begin
				for (int c = 0; c < NC; c++) begin
					logic [8:0] t;
					t = {1'b0, orig_q[c]} + {1'b0, glws_pkg::div255(prod_q[c])};
					res_q[c] <= t[8] ? 8'd255 : t[7:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			width_q <= glws_pkg::WIDTH_RESET;
			height_q <= glws_pkg::HEIGHT_RESET;
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			in_line_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			out_line_q <= '0;
			pend_q <= '0;
			ir_q <= '0;
			ik_q <= '0;
			pr_q <= '0;
			pk_q <= '0;
			cap_v_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tlast_q <= 1'b0;
			m_tdata_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index[0])
					glws_pkg::REG_WIDTH: width_q <= cfg_data[11:0];
					glws_pkg::REG_HEIGHT: height_q <= cfg_data;
					default: begin
					end
				endcase
			end
			cap_v_s1 <= (state_q == RD);
			if (m_tvalid_q && m_tready && state_q != OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					ir_q <= '0;
					ik_q <= '0;
					if (acc && s_tuser[0]) begin
						if (pend_q != '0) begin
							state_q <= RD;
						end
					end else if (acc) begin
						if (col_inc >= eff_w) begin
							col_cnt_q <= '0;
							in_line_q <= in_line_q + 3'd1;
							row_cnt_q <= (row_inc >= eff_h) ? 16'd0 : row_inc;
						end else begin
							col_cnt_q <= col_inc;
						end
						pend_q <= pend_inc;
						if (pend_inc > thr) begin
							state_q <= RD;
						end
					end
				end
				RD: begin
					if (ik_q == 3'd4) begin
						ik_q <= '0;
						ir_q <= ir_q + 3'd1;
					end else begin
						ik_q <= ik_q + 3'd1;
					end
					if (ir_q == 3'd4 && ik_q == 3'd4) begin
						state_q <= RDW;
					end
				end
				RDW: state_q <= LAP;
				LAP: begin
					pr_q <= '0;
					pk_q <= '0;
					state_q <= interior ? SQ : OUT;
				end
				SQ: state_q <= ST;
				ST: state_q <= WT;
				WT: begin
					if (done_all) begin
						if (pr_q == 2'd2 && pk_q == 2'd2) begin
							state_q <= MEAN;
						end else begin
							if (pk_q == 2'd2) begin
								pk_q <= '0;
								pr_q <= pr_q + 2'd1;
							end else begin
								pk_q <= pk_q + 2'd1;
							end
							state_q <= SQ;
						end
					end
				end
				MEAN: state_q <= PROD;
				PROD: state_q <= SCALE;
				SCALE: state_q <= OUT;
				OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q <= {res_q[2], res_q[1], res_q[0]};
						m_tlast_q <= (out_row_q == eff_h - 16'd1)
							&& (out_col_q == eff_w - 12'd1);
						if (ocol_inc >= eff_w) begin
							out_col_q <= '0;
							out_line_q <= out_line_q + 3'd1;
							out_row_q <= (orow_inc >= eff_h) ? 16'd0 : orow_inc;
						end else begin
							out_col_q <= ocol_inc;
						end
						pend_q <= pend_q - 13'd1;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ===== design/glws_checker.sv =====
// Port-level assertions for the sharpener top level, with its bind.
module glws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output transfer changed");

	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("input ready dropped without a transfer");

	a_load_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready && !$past(s_tready))
		else $error("result loaded outside the end of an item");

endmodule

bind gradient_weighted_laplacian_sharpen_top glws_checker u_glws_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
